[design/robot_life_mode_controller_unit_assert.svh]
// Assertion macros used by the mode controller core (rlmc_core).
`ifndef ROBOT_LIFE_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define ROBOT_LIFE_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define RLMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mode controller check failed");

// Next-cycle implication, checked outside of reset.
`define RLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mode controller check failed");

`endif

[design/rlmc_pkg.sv]
// Types and constants shared by the mode controller modules.
`default_nettype none

package rlmc_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_SLEEP_TIMEOUT = 3'd0;
    localparam logic [31:0] SLEEP_TIMEOUT_RESET = 32'd60000;

    typedef enum logic [3:0] {
        MODE_BOOT      = 4'd0,
        MODE_IDLE      = 4'd1,
        MODE_ATTENTIVE = 4'd2,
        MODE_ACTING    = 4'd3,
        MODE_SLEEPING  = 4'd4,
        MODE_PAUSED    = 4'd5,
        MODE_DEGRADED  = 4'd6,
        MODE_FAULT     = 4'd7,
        MODE_ESTOP     = 4'd8
    } mode_t;

    typedef enum logic [4:0] {
        CMD_BOOT_COMPLETE   = 5'd0,
        CMD_TOUCH           = 5'd1,
        CMD_PERSON_PRESENT  = 5'd2,
        CMD_PERSON_LEFT     = 5'd3,
        CMD_ACTION_STARTED  = 5'd4,
        CMD_ACTION_FINISHED = 5'd5,
        CMD_SLEEP           = 5'd6,
        CMD_WAKE            = 5'd7,
        CMD_RESUME          = 5'd8,
        CMD_RESTORED        = 5'd9,
        CMD_TICK            = 5'd10,
        CMD_CLEAR_FAULT     = 5'd11,
        CMD_FAULT           = 5'd12,
        CMD_PAUSE           = 5'd13,
        CMD_DEGRADED        = 5'd14,
        CMD_ESTOP           = 5'd15,
        CMD_CLEAR_ESTOP     = 5'd16
    } cmd_t;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] now;
        logic [63:0] transition_time;
        logic [63:0] interaction_time;
        logic [31:0] touch_total;
        logic        estop;
        logic        fault;
        logic        paused;
        logic        degraded;
        logic        person;
        logic        fresh_touch;
    } state_t;

endpackage

`default_nettype wire

[design/rlmc_apb.sv]
// APB register file holding the sleep timeout.
`default_nettype none

module rlmc_apb
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [rlmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output logic      [31:0]               sleep_timeout
);

    logic [31:0] timeout_reg;
    logic [31:0] timeout_next;
    logic        hit;

    // Only the word address matters; byte offsets within the word are ignored.
    assign hit = (paddr[rlmc_pkg::ADDR_W-1:2] == rlmc_pkg::REG_SLEEP_TIMEOUT[rlmc_pkg::ADDR_W-1:2]);

    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && hit)
        begin
            timeout_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rlmc_pkg::SLEEP_TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    assign prdata        = hit ? timeout_reg : 32'd0;
    assign pready        = 1'b1;
    assign sleep_timeout = timeout_reg;

endmodule

`default_nettype wire

[design/rlmc_core.sv]
// Mode state registers and the single-pass event update logic.
`default_nettype none
`include "robot_life_mode_controller_unit_assert.svh"

module rlmc_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [4:0]       cmd,
    input  wire logic [63:0]      event_time,
    input  wire logic [31:0]      sleep_timeout,
    output rlmc_pkg::state_t      st
);

    rlmc_pkg::state_t st_reg;
    rlmc_pkg::state_t st_next;

    logic        later;
    logic [63:0] now;
    logic [63:0] elapsed_new;
    logic [63:0] elapsed_old;
    logic [63:0] elapsed;
    logic        timed_out;

    // Time never runs backward. Both candidate elapsed times are formed in
    // parallel so the clamp and the subtract do not chain.
    assign later       = (event_time > st_reg.now);
    assign now         = later ? event_time : st_reg.now;
    assign elapsed_new = event_time - st_reg.interaction_time;
    assign elapsed_old = st_reg.now - st_reg.interaction_time;
    assign elapsed     = later ? elapsed_new : elapsed_old;
    assign timed_out   = (elapsed >= {32'd0, sleep_timeout});

    always_comb
    begin
        st_next     = st_reg;
        st_next.now = now;
        if (cmd == rlmc_pkg::CMD_ESTOP)
        begin
            st_next.estop           = 1'b1;
            st_next.mode            = rlmc_pkg::MODE_ESTOP;
            st_next.transition_time = now;
        end
        else if (st_reg.estop)
        begin
            if (cmd == rlmc_pkg::CMD_CLEAR_ESTOP)
            begin
                st_next.estop           = 1'b0;
                st_next.mode            = st_reg.fault ? rlmc_pkg::MODE_FAULT
                                                       : rlmc_pkg::MODE_IDLE;
                st_next.transition_time = now;
            end
        end
        else if (cmd == rlmc_pkg::CMD_FAULT)
        begin
            st_next.fault           = 1'b1;
            st_next.mode            = rlmc_pkg::MODE_FAULT;
            st_next.transition_time = now;
        end
        else if (st_reg.fault)
        begin
            if (cmd == rlmc_pkg::CMD_CLEAR_FAULT)
            begin
                st_next.fault           = 1'b0;
                st_next.mode            = rlmc_pkg::MODE_IDLE;
                st_next.transition_time = now;
            end
        end
        else
        begin
            unique case (rlmc_pkg::cmd_t'(cmd))
                rlmc_pkg::CMD_PAUSE:
                begin
                    st_next.paused          = 1'b1;
                    st_next.mode            = rlmc_pkg::MODE_PAUSED;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_DEGRADED:
                begin
                    st_next.degraded        = 1'b1;
                    st_next.mode            = st_reg.paused ? rlmc_pkg::MODE_PAUSED
                                                            : rlmc_pkg::MODE_DEGRADED;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_BOOT_COMPLETE:
                begin
                    if (st_reg.mode == rlmc_pkg::MODE_BOOT)
                    begin
                        st_next.mode            = rlmc_pkg::MODE_IDLE;
                        st_next.transition_time = now;
                    end
                end
                rlmc_pkg::CMD_TOUCH:
                begin
                    st_next.touch_total      = st_reg.touch_total + 32'd1;
                    st_next.interaction_time = now;
                    st_next.fresh_touch      = 1'b1;
                    st_next.mode             = rlmc_pkg::MODE_ATTENTIVE;
                    st_next.transition_time  = now;
                end
                rlmc_pkg::CMD_PERSON_PRESENT:
                begin
                    st_next.person          = 1'b1;
                    st_next.mode            = rlmc_pkg::MODE_ATTENTIVE;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_PERSON_LEFT:
                begin
                    st_next.person = 1'b0;
                    if (st_reg.mode == rlmc_pkg::MODE_ATTENTIVE)
                    begin
                        st_next.mode            = rlmc_pkg::MODE_IDLE;
                        st_next.transition_time = now;
                    end
                end
                rlmc_pkg::CMD_ACTION_STARTED:
                begin
                    st_next.mode            = rlmc_pkg::MODE_ACTING;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_ACTION_FINISHED:
                begin
                    st_next.mode            = st_reg.person ? rlmc_pkg::MODE_ATTENTIVE
                                                            : rlmc_pkg::MODE_IDLE;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_SLEEP:
                begin
                    st_next.mode            = rlmc_pkg::MODE_SLEEPING;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_WAKE:
                begin
                    st_next.mode             = rlmc_pkg::MODE_ATTENTIVE;
                    st_next.transition_time  = now;
                    st_next.interaction_time = now;
                end
                rlmc_pkg::CMD_RESUME:
                begin
                    st_next.paused          = 1'b0;
                    st_next.mode            = st_reg.degraded ? rlmc_pkg::MODE_DEGRADED
                                                              : rlmc_pkg::MODE_IDLE;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_RESTORED:
                begin
                    st_next.degraded        = 1'b0;
                    st_next.mode            = st_reg.paused ? rlmc_pkg::MODE_PAUSED
                                                            : rlmc_pkg::MODE_IDLE;
                    st_next.transition_time = now;
                end
                rlmc_pkg::CMD_TICK:
                begin
                    st_next.fresh_touch = 1'b0;
                    if (st_reg.mode == rlmc_pkg::MODE_IDLE && !st_reg.person && timed_out)
                    begin
                        st_next.mode            = rlmc_pkg::MODE_SLEEPING;
                        st_next.transition_time = now;
                    end
                end
                default:
                begin
                    // Unknown events and stray clears only move the clock.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode             <= rlmc_pkg::MODE_BOOT;
            st_reg.now              <= 64'd0;
            st_reg.transition_time  <= 64'd0;
            st_reg.interaction_time <= 64'd0;
            st_reg.touch_total      <= 32'd0;
            st_reg.estop            <= 1'b0;
            st_reg.fault            <= 1'b0;
            st_reg.paused           <= 1'b0;
            st_reg.degraded         <= 1'b0;
            st_reg.person           <= 1'b0;
            st_reg.fresh_touch      <= 1'b0;
        end
        else if (load)
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

    `RLMC_ASSERT_IMPLY(a_estop_mode, clk, rst_n, st_reg.estop,
        st_reg.mode == rlmc_pkg::MODE_ESTOP)
    `RLMC_ASSERT_IMPLY(a_fault_mode, clk, rst_n, st_reg.fault && !st_reg.estop,
        st_reg.mode == rlmc_pkg::MODE_FAULT)
    `RLMC_ASSERT_NEXT(a_time_monotonic, clk, rst_n, load, st_reg.now >= $past(st_reg.now))
    `RLMC_ASSERT_IMPLY(a_times_behind_now, clk, rst_n, 1'b1,
        st_reg.transition_time <= st_reg.now && st_reg.interaction_time <= st_reg.now)

endmodule

`default_nettype wire

[design/robot_life_mode_controller_unit.sv]
// Top level of the robot operating-mode controller.
`default_nettype none

// The controller takes one timestamped event per request on the req channel
// and returns one result per request on the res channel that carries the
// full controller state after that event. An accepted request is held in an
// input register until the result slot is free or is being emptied; it then
// runs through the update logic into the state registers, which double as
// the result register, so a result passes through both registers before it
// is presented, and one request can be accepted every cycle
// when results are taken promptly. While a result waits for res_ready, the
// input register can still take one more request. The event time is clamped
// so that time never runs backward; an emergency stop overrides everything
// until cleared, then a fault latch does the same. The sleep timeout is
// written through the APB port at byte address 0 and should only be changed
// while no request is in flight.
module robot_life_mode_controller_unit
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rlmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,

    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [4:0]                  cmd,
    input  wire logic [63:0]                 event_time,

    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic      [3:0]                  mode_out,
    output logic      [63:0]                 now_out,
    output logic      [63:0]                 transition_time_out,
    output logic      [63:0]                 interaction_time_out,
    output logic      [31:0]                 touch_total_out,
    output logic                             estop_latched_out,
    output logic                             fault_latched_out,
    output logic                             paused_out,
    output logic                             degraded_out,
    output logic                             person_out,
    output logic                             touch_recent_out
);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [4:0]       cmd_reg;
    logic [63:0]      time_reg;
    logic             res_valid_reg;
    logic             res_valid_next;
    logic             advance;
    logic [31:0]      sleep_timeout;
    rlmc_pkg::state_t st;

    rlmc_apb u_apb
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .sleep_timeout (sleep_timeout)
    );

    // The held request moves into the state whenever the result slot is free
    // or is being emptied in this same cycle.
    assign advance   = in_valid_reg && (!res_valid_reg || res_ready);
    assign req_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_valid && req_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            cmd_reg  <= cmd;
            time_reg <= event_time;
        end
    end

    rlmc_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .cmd           (cmd_reg),
        .event_time    (time_reg),
        .sleep_timeout (sleep_timeout),
        .st            (st)
    );

    // The state only changes when a new result is loaded, so it stays
    // stable while a result waits to be taken.
    assign res_valid            = res_valid_reg;
    assign mode_out             = st.mode;
    assign now_out              = st.now;
    assign transition_time_out  = st.transition_time;
    assign interaction_time_out = st.interaction_time;
    assign touch_total_out      = st.touch_total;
    assign estop_latched_out    = st.estop;
    assign fault_latched_out    = st.fault;
    assign paused_out           = st.paused;
    assign degraded_out         = st.degraded;
    assign person_out           = st.person;
    assign touch_recent_out     = st.fresh_touch;

endmodule

`default_nettype wire
